/* rtl/tpbp_pkg.sv */
package tpbp_pkg;

  localparam int WORD_WIDTH     = 32;
  localparam int RAW_WIDTH      = 16;
  localparam int ESC_PREFIX_LEN = 7;
  localparam logic [ESC_PREFIX_LEN-1:0] ESC_PREFIX = 7'h7F;

  // longest code: seven ones, a zero and a full-width index
  localparam int CODE_WIDTH = 24;
  localparam int LEN_WIDTH  = 5;
  localparam int FILL_WIDTH = 5;
  // pending bits (below one word) followed by one code
  localparam int COMB_WIDTH = WORD_WIDTH + CODE_WIDTH;
  localparam int TOT_WIDTH  = 6;

  localparam int TOTAL_BITS_WIDTH = 40;
  localparam int COUNT_WIDTH      = 32;
  localparam int POS_WIDTH        = 16;
  localparam int VPB_WIDTH        = 17;
  localparam int IW_WIDTH         = 5;
  localparam int KIND_WIDTH       = 3;

  localparam logic [IW_WIDTH-1:0]  INDEX_WIDTH_RESET = 5'd8;
  localparam logic [IW_WIDTH-1:0]  INDEX_WIDTH_MAX   = 5'd16;
  localparam logic [VPB_WIDTH-1:0] VPB_RESET         = 17'd256;
  localparam logic [VPB_WIDTH-1:0] VPB_MAX           = 17'd65536;

  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 17;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INDEX_WIDTH_REG = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VALUES_PER_BLOCK = 1'b1;

  localparam logic [KIND_WIDTH-1:0] KIND_WORD    = 3'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_ESCAPE  = 3'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_POINTER = 3'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_TOTALS  = 3'd3;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // which results a request causes, in delivery order from the top member
  typedef struct packed {
    logic ptr;
    logic esc;
    logic word;
    logic flush;
    logic tot;
  } flags_t;

  localparam int NUM_FLAGS = 5;

  typedef struct packed {
    flags_t                       flags;
    logic [WORD_WIDTH-1:0]        ptr_offset;
    logic [COUNT_WIDTH-1:0]       ptr_escapes;
    logic [RAW_WIDTH-1:0]         raw;
    logic [WORD_WIDTH-1:0]        word;
    logic [WORD_WIDTH-1:0]        flush_word;
    logic [TOTAL_BITS_WIDTH-1:0]  tot_bits;
    logic [COUNT_WIDTH-1:0]       tot_escapes;
  } record_t;

endpackage

/* rtl/tpbp_front.sv */
module tpbp_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic                                  q_full,
  input  logic                                  is_escape,
  input  logic [2:0]                            tier,
  input  logic [15:0]                           code_index,
  input  logic [tpbp_pkg::RAW_WIDTH-1:0]        raw_value,
  input  logic                                  end_of_stream,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tpbp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [tpbp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  output logic                                  q_push,
  output tpbp_pkg::record_t                     q_rec
);

  logic [tpbp_pkg::IW_WIDTH-1:0]          index_width;
  logic [tpbp_pkg::VPB_WIDTH-1:0]         values_per_block;
  logic [tpbp_pkg::WORD_WIDTH-1:0]        acc;
  logic [tpbp_pkg::FILL_WIDTH-1:0]        fill;
  logic [tpbp_pkg::TOTAL_BITS_WIDTH-1:0]  bit_total;
  logic [tpbp_pkg::COUNT_WIDTH-1:0]       escapes;
  logic [tpbp_pkg::POS_WIDTH-1:0]         pos;

  logic [tpbp_pkg::WORD_WIDTH-1:0]        acc_next;
  logic [tpbp_pkg::FILL_WIDTH-1:0]        fill_next;
  logic [tpbp_pkg::TOTAL_BITS_WIDTH-1:0]  bit_total_next;
  logic [tpbp_pkg::COUNT_WIDTH-1:0]       escapes_next;
  logic [tpbp_pkg::POS_WIDTH-1:0]         pos_next;

  logic                                   accept;
  logic [tpbp_pkg::IW_WIDTH-1:0]          w;
  logic [tpbp_pkg::VPB_WIDTH-1:0]         vpb;
  logic [7:0]                             prefix;
  logic [16:0]                            idx_mask;
  logic [tpbp_pkg::CODE_WIDTH-1:0]        code;
  logic [tpbp_pkg::LEN_WIDTH-1:0]         len;
  logic [tpbp_pkg::COMB_WIDTH-1:0]        comb;
  logic [tpbp_pkg::COMB_WIDTH-1:0]        comb_rest;
  logic [tpbp_pkg::TOT_WIDTH-1:0]         tot;
  logic [tpbp_pkg::TOT_WIDTH-1:0]         tot_rest;
  logic                                   word_done;
  logic [tpbp_pkg::VPB_WIDTH-1:0]         pos_inc;
  logic [tpbp_pkg::TOT_WIDTH-1:0]         pad_shift;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;

  always_comb begin
    w = index_width;
    if (w == '0) begin
      w = 5'd1;
    end else if (w > tpbp_pkg::INDEX_WIDTH_MAX) begin
      w = tpbp_pkg::INDEX_WIDTH_MAX;
    end
    vpb = values_per_block;
    if (vpb == '0) begin
      vpb = 17'd1;
    end else if (vpb > tpbp_pkg::VPB_MAX) begin
      vpb = tpbp_pkg::VPB_MAX;
    end
  end

  // classify: build the code and its length
  always_comb begin
    prefix   = ((8'd1 << tier) - 8'd1) << 1;
    idx_mask = (17'd1 << w) - 17'd1;
    if (is_escape) begin
      code = {1'b0, tpbp_pkg::ESC_PREFIX, raw_value};
      len  = 5'(tpbp_pkg::ESC_PREFIX_LEN + tpbp_pkg::RAW_WIDTH);
    end else begin
      code = ({16'd0, prefix} << w) | {8'd0, code_index & idx_mask[15:0]};
      len  = {2'b00, tier} + 5'd1 + w;
    end
  end

  // pack: append the code and split off a full word
  always_comb begin
    comb      = ({{tpbp_pkg::CODE_WIDTH{1'b0}}, acc} << len)
              | {{tpbp_pkg::WORD_WIDTH{1'b0}}, code};
    tot       = {1'b0, fill} + {1'b0, len};
    word_done = tot >= 6'(tpbp_pkg::WORD_WIDTH);
    tot_rest  = word_done ? tot - 6'(tpbp_pkg::WORD_WIDTH) : tot;
    comb_rest = comb & ((56'd1 << tot_rest) - 56'd1);
    pad_shift = 6'(tpbp_pkg::WORD_WIDTH) - tot_rest;
    pos_inc   = {1'b0, pos} + 17'd1;
  end

  always_comb begin
    q_rec                   = '0;
    q_rec.flags.ptr         = pos == '0;
    q_rec.flags.esc         = is_escape;
    q_rec.flags.word        = word_done;
    q_rec.flags.flush       = end_of_stream && (tot_rest != '0);
    q_rec.flags.tot         = end_of_stream;
    q_rec.ptr_offset        = bit_total[tpbp_pkg::WORD_WIDTH-1:0];
    q_rec.ptr_escapes       = escapes;
    q_rec.raw               = raw_value;
    q_rec.word              = 32'(comb >> tot_rest);
    q_rec.flush_word        = comb_rest[tpbp_pkg::WORD_WIDTH-1:0] << pad_shift;
    q_rec.tot_bits          = bit_total + {35'd0, len};
    q_rec.tot_escapes       = escapes + {31'd0, is_escape};
    q_push                  = accept && (q_rec.flags != '0);
  end

  always_comb begin
    acc_next       = comb_rest[tpbp_pkg::WORD_WIDTH-1:0];
    fill_next      = tot_rest[tpbp_pkg::FILL_WIDTH-1:0];
    bit_total_next = q_rec.tot_bits;
    escapes_next   = q_rec.tot_escapes;
    pos_next       = (pos_inc >= vpb) ? '0 : pos_inc[tpbp_pkg::POS_WIDTH-1:0];
    if (end_of_stream) begin
      acc_next       = '0;
      fill_next      = '0;
      bit_total_next = '0;
      escapes_next   = '0;
      pos_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      fill      <= '0;
      bit_total <= '0;
      escapes   <= '0;
      pos       <= '0;
    end else if (accept) begin
      acc       <= acc_next;
      fill      <= fill_next;
      bit_total <= bit_total_next;
      escapes   <= escapes_next;
      pos       <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_width      <= tpbp_pkg::INDEX_WIDTH_RESET;
      values_per_block <= tpbp_pkg::VPB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpbp_pkg::CFG_INDEX_WIDTH_REG:  index_width      <= cfg_data[tpbp_pkg::IW_WIDTH-1:0];
        tpbp_pkg::CFG_VALUES_PER_BLOCK: values_per_block <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tpbp_queue.sv */
module tpbp_queue #(
  parameter int DEPTH = tpbp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  tpbp_pkg::record_t  wr_rec,
  output logic               full,
  input  logic               rd_en,
  output logic               rd_valid,
  output tpbp_pkg::record_t  rd_rec
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tpbp_pkg::record_t   mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_wr;
  logic                do_rd;

  assign full     = count == CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_rec   = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/tpbp_back.sv */
module tpbp_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  tpbp_pkg::record_t                     q_rec,
  output logic                                  q_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [tpbp_pkg::KIND_WIDTH-1:0]       kind,
  output logic [tpbp_pkg::WORD_WIDTH-1:0]       packed_word,
  output logic [tpbp_pkg::RAW_WIDTH-1:0]        escape_value,
  output logic [31:0]                           block_bit_offset,
  output logic [31:0]                           block_escape_index,
  output logic [tpbp_pkg::TOTAL_BITS_WIDTH-1:0] total_bits,
  output logic [tpbp_pkg::COUNT_WIDTH-1:0]      escape_count,
  output logic                                  last_of_run
);

  tpbp_pkg::record_t   rec;
  tpbp_pkg::flags_t    mask;
  tpbp_pkg::flags_t    mask_clr;
  logic                busy;
  logic                take;

  assign busy  = mask != '0;
  assign empty = !busy;

  // pick the first pending result and drop it from the mask
  always_comb begin
    mask_clr           = mask;
    kind               = tpbp_pkg::KIND_WORD;
    packed_word        = '0;
    escape_value       = '0;
    block_bit_offset   = '0;
    block_escape_index = '0;
    total_bits         = '0;
    escape_count       = '0;
    if (mask.ptr) begin
      mask_clr.ptr       = 1'b0;
      kind               = tpbp_pkg::KIND_POINTER;
      block_bit_offset   = rec.ptr_offset;
      block_escape_index = rec.ptr_escapes;
    end else if (mask.esc) begin
      mask_clr.esc = 1'b0;
      kind         = tpbp_pkg::KIND_ESCAPE;
      escape_value = rec.raw;
    end else if (mask.word) begin
      mask_clr.word = 1'b0;
      packed_word   = rec.word;
    end else if (mask.flush) begin
      mask_clr.flush = 1'b0;
      packed_word    = rec.flush_word;
    end else if (mask.tot) begin
      mask_clr.tot = 1'b0;
      kind         = tpbp_pkg::KIND_TOTALS;
      total_bits   = rec.tot_bits;
      escape_count = rec.tot_escapes;
    end
    last_of_run = busy && (mask_clr == '0);
  end

  assign take  = q_valid && (!busy || (pop && last_of_run));
  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (take) begin
      rec <= q_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (take) begin
      mask <= q_rec.flags;
    end else if (pop && busy) begin
      mask <= mask_clr;
    end
  end

`ifndef ASSERT_OFF
  a_totals_last: assert property (@(posedge clk) disable iff (rst)
    (busy && kind == tpbp_pkg::KIND_TOTALS) |-> last_of_run)
    else $error("totals result is not the last of its request");
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (pop && busy && !last_of_run) |=> busy)
    else $error("results of a request lost mid-run");
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> busy)
    else $error("queued request carried no results");
`endif

endmodule

/* rtl/tiered_prefix_bit_packer_unit.sv */
// Tiered prefix-code bit packer with escape.
// Input channel (push/full): one coded value per request, either a tier plus
// codebook index or an escape carrying a raw 16-bit value, with an
// end_of_stream flag. A request is taken on a clock edge with push high and
// full low; a new request may follow on every cycle.
// Result channel (empty/pop): the oldest result sits on the ports while empty
// is low and leaves on an edge with pop high. kind tells a packed word, an
// escape value, a block pointer or the stream totals; last_of_run marks the
// final result of its request. A request makes zero to five results.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 is index_width,
// index 1 is values_per_block; write only while the block is idle.
// A taken request is written to the queue, then loaded into the result stage.
// Throughput: one request per cycle in the front stage while full is low; while
// pop is high the result port moves one result per cycle, so a run of requests
// that average more than one result each is paced by pop at one result per
// cycle. A queue of QUEUE_DEPTH requests sits between packing and delivery.
// When the receiver stalls the queue fills and full rises; no result is lost.
// Reset (rst, synchronous) clears the stream state, empties the queue and
// restores index_width to 8 and values_per_block to 256.
module tiered_prefix_bit_packer_unit #(
  parameter int QUEUE_DEPTH = tpbp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input requests
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  is_escape,
  input  logic [2:0]                            tier,
  input  logic [15:0]                           code_index,
  input  logic [tpbp_pkg::RAW_WIDTH-1:0]        raw_value,
  input  logic                                  end_of_stream,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tpbp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [tpbp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  // results
  output logic                                  empty,
  input  logic                                  pop,
  output logic [tpbp_pkg::KIND_WIDTH-1:0]       kind,
  output logic [tpbp_pkg::WORD_WIDTH-1:0]       packed_word,
  output logic [tpbp_pkg::RAW_WIDTH-1:0]        escape_value,
  output logic [31:0]                           block_bit_offset,
  output logic [31:0]                           block_escape_index,
  output logic [tpbp_pkg::TOTAL_BITS_WIDTH-1:0] total_bits,
  output logic [tpbp_pkg::COUNT_WIDTH-1:0]      escape_count,
  output logic                                  last_of_run
);

  // front to queue: one record per request that makes any result
  logic               q_push;
  logic               q_full;
  tpbp_pkg::record_t  q_wr_rec;
  // queue to back
  logic               q_valid;
  logic               q_pop;
  tpbp_pkg::record_t  q_rd_rec;

  assign full = q_full;

  // classify, pack bits and advance the stream counters
  tpbp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .q_full        (q_full),
    .is_escape     (is_escape),
    .tier          (tier),
    .code_index    (code_index),
    .raw_value     (raw_value),
    .end_of_stream (end_of_stream),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_push        (q_push),
    .q_rec         (q_wr_rec)
  );

  // hold packed requests while the receiver stalls
  tpbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_rec   (q_wr_rec),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_rec   (q_rd_rec)
  );

  // deliver the results of each request in order, one per pop
  tpbp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_rec              (q_rd_rec),
    .q_pop              (q_pop),
    .empty              (empty),
    .pop                (pop),
    .kind               (kind),
    .packed_word        (packed_word),
    .escape_value       (escape_value),
    .block_bit_offset   (block_bit_offset),
    .block_escape_index (block_escape_index),
    .total_bits         (total_bits),
    .escape_count       (escape_count),
    .last_of_run        (last_of_run)
  );

endmodule

/* test/tb_tiered_prefix_bit_packer_unit.sv */
module tb_tiered_prefix_bit_packer_unit;

  // One coded value as it crosses the input port
  typedef struct packed {
    logic        esc;
    logic [2:0]  tier;
    logic [15:0] idx;
    logic [15:0] raw;
    logic        eos;
  } value_req_t;

  // One result as it leaves the output port; order matches the port list
  typedef struct packed {
    logic [tpbp_pkg::KIND_WIDTH-1:0]       kind;
    logic [tpbp_pkg::WORD_WIDTH-1:0]       word;
    logic [tpbp_pkg::RAW_WIDTH-1:0]        esc_val;
    logic [31:0]                           boff;
    logic [31:0]                           besc;
    logic [tpbp_pkg::TOTAL_BITS_WIDTH-1:0] tbits;
    logic [tpbp_pkg::COUNT_WIDTH-1:0]      ecount;
    logic                                  last;
  } result_t;

  // Register settings and traffic shape of one random phase
  typedef struct packed {
    int iw;
    int vpb;
    int send_pct;
    int recv_pct;
    int count;
    int hold;
  } phase_t;

  localparam int N_DIRECTED = 24;
  localparam int N_TYPED    = 13;
  localparam int N_PHASES   = 8;
  localparam int EOS_PCT    = 6;
  localparam int SETTLE     = 8;

  logic                                  clk;
  logic                                  rst;
  logic                                  push;
  logic                                  full;
  logic                                  is_escape;
  logic [2:0]                            tier;
  logic [15:0]                           code_index;
  logic [tpbp_pkg::RAW_WIDTH-1:0]        raw_value;
  logic                                  end_of_stream;
  logic                                  cfg_valid;
  logic                                  cfg_ready;
  logic [tpbp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index;
  logic [tpbp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data;
  logic                                  empty;
  logic                                  pop;
  logic [tpbp_pkg::KIND_WIDTH-1:0]       kind;
  logic [tpbp_pkg::WORD_WIDTH-1:0]       packed_word;
  logic [tpbp_pkg::RAW_WIDTH-1:0]        escape_value;
  logic [31:0]                           block_bit_offset;
  logic [31:0]                           block_escape_index;
  logic [tpbp_pkg::TOTAL_BITS_WIDTH-1:0] total_bits;
  logic [tpbp_pkg::COUNT_WIDTH-1:0]      escape_count;
  logic                                  last_of_run;

  // Packer state as this bench expects it to be
  logic [63:0]                       pend_bits;
  int unsigned                       pend_fill;
  logic [39:0]                       bits_written;
  logic [31:0]                       escapes_seen;
  int unsigned                       blk_pos;
  logic [tpbp_pkg::IW_WIDTH-1:0]     cfg_iw;
  logic [tpbp_pkg::VPB_WIDTH-1:0]    cfg_vpb;

  result_t run_buf[$];
  result_t expected_results[$];
  int      errors;

  // Side band travelling with each request: how many typed results it owns and
  // where they start in the typed table; -1 hands the request to the predictor
  int typed_n;
  int typed_at;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  // Directed requests. Opening rows are whole one-item streams under reset
  // settings (index width 8), whose results are typed in below.
  value_req_t directed_reqs [N_DIRECTED] = '{
    '{1'b0, 3'd0, 16'h0000, 16'h0000, 1'b1},   // shortest code, flushed alone
    '{1'b1, 3'd5, 16'h1234, 16'hFFFF, 1'b1},   // escape; tier and index ignored
    '{1'b0, 3'd6, 16'hFFFF, 16'hABCD, 1'b1},   // tier six, all-ones index; raw ignored
    '{1'b0, 3'd7, 16'h0000, 16'h0000, 1'b1},   // tier seven taken as given
    '{1'b1, 3'd7, 16'hFFFF, 16'h0000, 1'b0},
    '{1'b0, 3'd0, 16'hFFFF, 16'hFFFF, 1'b0},
    '{1'b0, 3'd1, 16'h00AA, 16'h0000, 1'b0},
    '{1'b0, 3'd2, 16'h5555, 16'h0000, 1'b0},
    '{1'b0, 3'd3, 16'h8000, 16'h0000, 1'b0},
    '{1'b0, 3'd4, 16'h00FF, 16'h0000, 1'b0},
    '{1'b0, 3'd5, 16'h0001, 16'h0000, 1'b0},
    '{1'b0, 3'd6, 16'h0000, 16'h0000, 1'b0},
    '{1'b0, 3'd7, 16'hFFFF, 16'h0000, 1'b0},
    '{1'b1, 3'd0, 16'h0000, 16'h8001, 1'b0},
    '{1'b1, 3'd0, 16'h0000, 16'hFFFF, 1'b0},
    '{1'b1, 3'd2, 16'h7777, 16'h1234, 1'b0},
    '{1'b0, 3'd0, 16'h0000, 16'h0000, 1'b1},   // close with a partial word
    '{1'b1, 3'd0, 16'h0000, 16'h0000, 1'b1},   // stream of one escape
    '{1'b0, 3'd3, 16'h00F0, 16'h0000, 1'b0},
    '{1'b0, 3'd6, 16'hFFFF, 16'h0000, 1'b0},
    '{1'b1, 3'd1, 16'h0000, 16'h5A5A, 1'b0},
    '{1'b0, 3'd5, 16'h0000, 16'h0000, 1'b1},
    '{1'b0, 3'd7, 16'h00C3, 16'h0000, 1'b0},   // two 16-bit codes end exactly
    '{1'b0, 3'd7, 16'h003C, 16'h0000, 1'b1}    // on a word: no flush word
  };

  int directed_typed [N_DIRECTED] = '{
    3, 4, 3, 3, -1, -1, -1, -1, -1, -1, -1, -1,
    -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1
  };

  result_t typed_results [N_TYPED] = '{
    '{tpbp_pkg::KIND_POINTER, 32'h0, 16'h0, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_WORD, 32'h00000000, 16'h0, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_TOTALS, 32'h0, 16'h0, 32'h0, 32'h0, 40'd9, 32'd0, 1'b1},
    '{tpbp_pkg::KIND_POINTER, 32'h0, 16'h0, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_ESCAPE, 32'h0, 16'hFFFF, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_WORD, 32'hFFFFFE00, 16'h0, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_TOTALS, 32'h0, 16'h0, 32'h0, 32'h0, 40'd23, 32'd1, 1'b1},
    '{tpbp_pkg::KIND_POINTER, 32'h0, 16'h0, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_WORD, 32'hFDFE0000, 16'h0, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_TOTALS, 32'h0, 16'h0, 32'h0, 32'h0, 40'd15, 32'd0, 1'b1},
    '{tpbp_pkg::KIND_POINTER, 32'h0, 16'h0, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_WORD, 32'hFE000000, 16'h0, 32'h0, 32'h0, 40'd0, 32'd0, 1'b0},
    '{tpbp_pkg::KIND_TOTALS, 32'h0, 16'h0, 32'h0, 32'h0, 40'd16, 32'd0, 1'b1}
  };

  // Random phases: iw, vpb, sender idle %, receiver stall %, requests, hold-off.
  // Out-of-range register values check the clamping of width and block size.
  phase_t phases [N_PHASES] = '{
    '{1,  1,      0,  0,  55, 0},
    '{16, 65536,  88, 0,  50, 0},
    '{0,  0,      0,  88, 50, 0},
    '{31, 131071, 11, 11, 50, 0},
    '{5,  7,      0,  0,  70, 80},
    '{17, 3,      88, 0,  50, 0},
    '{12, 2,      0,  88, 50, 0},
    '{3,  20,     11, 11, 50, 0}
  };

  tiered_prefix_bit_packer_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Backstop: far beyond the slowest legal run
  initial begin
    #6000000;
    $display("tb_tiered_prefix_bit_packer_unit NOT OK");
    $finish;
  end

  // Work out the results of one request and advance the expected packer state.
  // Results land in run_buf in delivery order.
  function automatic void pack_value(input value_req_t rq);
    int unsigned w;
    int unsigned vpb;
    int unsigned len;
    int unsigned tot;
    logic [63:0] code;
    logic [63:0] comb;
    logic [63:0] prefix;
    result_t     r;
    run_buf.delete();
    w = 32'(cfg_iw);
    if (w < 1) w = 1;
    if (w > tpbp_pkg::RAW_WIDTH) w = tpbp_pkg::RAW_WIDTH;
    vpb = 32'(cfg_vpb);
    if (vpb < 1) vpb = 1;
    if (vpb > 65536) vpb = 65536;

    // block pointer leads whenever this value opens a block
    if (blk_pos == 0) begin
      r = '0;
      r.kind = tpbp_pkg::KIND_POINTER;
      r.boff = bits_written[31:0];
      r.besc = escapes_seen;
      run_buf.push_back(r);
    end

    if (rq.esc) begin
      code = {41'd0, tpbp_pkg::ESC_PREFIX, rq.raw};
      len = tpbp_pkg::ESC_PREFIX_LEN + tpbp_pkg::RAW_WIDTH;
      r = '0;
      r.kind = tpbp_pkg::KIND_ESCAPE;
      r.esc_val = rq.raw;
      run_buf.push_back(r);
      escapes_seen = escapes_seen + 32'd1;
    end else begin
      prefix = ((64'd1 << rq.tier) - 64'd1) << 1;
      code = (prefix << w) | (64'(rq.idx) & ((64'd1 << w) - 64'd1));
      len = 32'(rq.tier) + 1 + w;
    end
    bits_written = bits_written + 40'(len);

    // append the code below the pending bits; peel off a full word if one formed
    comb = (pend_bits << len) | code;
    tot = pend_fill + len;
    if (tot >= tpbp_pkg::WORD_WIDTH) begin
      tot = tot - tpbp_pkg::WORD_WIDTH;
      r = '0;
      r.kind = tpbp_pkg::KIND_WORD;
      r.word = 32'(comb >> tot);
      run_buf.push_back(r);
      comb = comb & ((64'd1 << tot) - 64'd1);
    end
    pend_bits = comb;
    pend_fill = tot;
    blk_pos = (blk_pos + 1 >= vpb) ? 0 : blk_pos + 1;

    if (rq.eos) begin
      if (pend_fill != 0) begin
        r = '0;
        r.kind = tpbp_pkg::KIND_WORD;
        r.word = 32'(pend_bits << (tpbp_pkg::WORD_WIDTH - pend_fill));
        run_buf.push_back(r);
      end
      r = '0;
      r.kind = tpbp_pkg::KIND_TOTALS;
      r.tbits = bits_written;
      r.ecount = escapes_seen;
      run_buf.push_back(r);
      pend_bits = '0;
      pend_fill = 0;
      bits_written = '0;
      escapes_seen = '0;
      blk_pos = 0;
    end

    if (run_buf.size() > 0) begin
      r = run_buf.pop_back();
      r.last = 1'b1;
      run_buf.push_back(r);
    end
  endfunction

  task automatic report(input string what, input result_t want, input result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: exp kind=%0d word=%h esc=%h boff=%h besc=%h bits=%h cnt=%h last=%b",
               $time, what, want.kind, want.word, want.esc_val, want.boff, want.besc,
               want.tbits, want.ecount, want.last);
      $display("%0t %s: got kind=%0d word=%h esc=%h boff=%h besc=%h bits=%h cnt=%h last=%b",
               $time, what, got.kind, got.word, got.esc_val, got.boff, got.besc,
               got.tbits, got.ecount, got.last);
    end
  endtask

  // Scoreboard: check the result leaving at this edge against the oldest
  // expectation, then predict for the request taken at this edge, then apply
  // any register write so that it counts from the next request on.
  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    if (rst) begin
      pend_bits = '0;
      pend_fill = 0;
      bits_written = '0;
      escapes_seen = '0;
      blk_pos = 0;
      cfg_iw = tpbp_pkg::INDEX_WIDTH_RESET;
      cfg_vpb = tpbp_pkg::VPB_RESET;
    end else begin
      if (pop && !empty) begin
        got = {kind, packed_word, escape_value, block_bit_offset, block_escape_index,
               total_bits, escape_count, last_of_run};
        if (expected_results.size() == 0) begin
          report("result with nothing expected", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) report("result mismatch", want, got);
        end
      end
      if (push && !full) begin
        pack_value({is_escape, tier, code_index, raw_value, end_of_stream});
        if (typed_n < 0) begin
          foreach (run_buf[i]) expected_results.push_back(run_buf[i]);
        end else begin
          for (int i = 0; i < typed_n; i++)
            expected_results.push_back(typed_results[typed_at + i]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tpbp_pkg::CFG_INDEX_WIDTH_REG)
          cfg_iw = cfg_data[tpbp_pkg::IW_WIDTH-1:0];
        else if (cfg_index == tpbp_pkg::CFG_VALUES_PER_BLOCK)
          cfg_vpb = cfg_data;
      end
    end
  end

  // Receiver: stall at the phase's rate, or hold pop low through a counted
  // hold-off so that the block backs up and raises full.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Present one request and hold it until taken; leave push high on return
  task automatic offer(input value_req_t rq, input int tn, input int ta);
    push          <= 1'b1;
    is_escape     <= rq.esc;
    tier          <= rq.tier;
    code_index    <= rq.idx;
    raw_value     <= rq.raw;
    end_of_stream <= rq.eos;
    typed_n       <= tn;
    typed_at      <= ta;
    do @(posedge clk); while (full);
  endtask

  // Drop push, let the scoreboard log the last request, wait for every
  // expected result, then cover requests that make no result.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tpbp_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [tpbp_pkg::CFG_DATA_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random request; extremes of index and raw value turn up often
  function automatic value_req_t random_req();
    value_req_t r;
    r.esc  = ($urandom_range(99) < 20);
    r.tier = 3'($urandom_range(7));
    case ($urandom_range(3))
      0:       r.idx = 16'h0000;
      1:       r.idx = 16'hFFFF;
      default: r.idx = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0:       r.raw = 16'h0000;
      1:       r.raw = 16'hFFFF;
      default: r.raw = 16'($urandom);
    endcase
    r.eos = ($urandom_range(99) < EOS_PCT);
    return r;
  endfunction

  initial begin : stimulus
    int at;
    int guard;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    at             = 0;

    // drive every input to a known value before the first edge
    rst           <= 1'b1;
    push          <= 1'b0;
    is_escape     <= 1'b0;
    tier          <= '0;
    code_index    <= '0;
    raw_value     <= '0;
    end_of_stream <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= tpbp_pkg::CFG_INDEX_WIDTH_REG;
    cfg_data      <= '0;
    typed_n       <= -1;
    typed_at      <= 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table under reset settings, back to back
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(directed_reqs[i], directed_typed[i], at);
      if (directed_typed[i] > 0) at += directed_typed[i];
    end

    // random phases; reprogram only once the block has gone quiet
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_reg(tpbp_pkg::CFG_INDEX_WIDTH_REG,
                phases[p].iw[tpbp_pkg::CFG_DATA_WIDTH-1:0]);
      write_reg(tpbp_pkg::CFG_VALUES_PER_BLOCK,
                phases[p].vpb[tpbp_pkg::CFG_DATA_WIDTH-1:0]);
      send_idle_pct  = phases[p].send_pct;
      recv_stall_pct = phases[p].recv_pct;
      hold_left      = phases[p].hold;
      for (int k = 0; k < phases[p].count; k++) begin
        while ($urandom_range(99) < send_idle_pct) begin
          push <= 1'b0;
          @(posedge clk);
        end
        offer(random_req(), -1, 0);
      end
    end

    // drain with the receiver always ready, bounded, then watch for strays
    push <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk);
    guard = 0;
    while (expected_results.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    errors += expected_results.size();
    repeat (20) @(posedge clk);

    if (errors == 0)
      $display("tb_tiered_prefix_bit_packer_unit OK");
    else
      $display("tb_tiered_prefix_bit_packer_unit NOT OK");
    $finish;
  end

endmodule
